/* rtl/median_filter_3x3_unit_macros.svh */
// Assertion macros for the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_UNIT_MACROS_SVH
`define MEDIAN_FILTER_3X3_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MF3_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mf3 check failed");

// Next-cycle implication, also checked across reset.
`define MF3_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mf3 check failed");

`endif

/* rtl/mf3_pkg.sv */
// Types and constants of the 3x3 median filter.
`default_nettype none
package mf3_pkg;
  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 17;
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 16;
  localparam int CHANNELS    = 3;
  localparam int CHAN_W      = 8;
  localparam int TAPS        = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_COLOR_MODE   = 2'd2
  } cfg_idx_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] pix_t;

  // One window ready for the median network, border taps already zeroed.
  typedef struct packed {
    pix_t [TAPS-1:0] taps;
    logic            frame_end;
  } win_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              push;
    logic              pop;
  } q_stat_t;
endpackage
`default_nettype wire

/* rtl/mf3_pix_if.sv */
// Input pixel channel.
`default_nettype none
interface mf3_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic       is_flush;
  modport source (output valid, chan_a, chan_b, chan_c, is_flush, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, is_flush, output ready);
endinterface
`default_nettype wire

/* rtl/mf3_med_if.sv */
// Output median channel.
`default_nettype none
interface mf3_med_if;
  logic       valid;
  logic       ready;
  logic [7:0] med_a;
  logic [7:0] med_b;
  logic [7:0] med_c;
  logic       frame_end;
  modport source (output valid, med_a, med_b, med_c, frame_end, input ready);
  modport sink (input valid, med_a, med_b, med_c, frame_end, output ready);
endinterface
`default_nettype wire

/* rtl/mf3_front.sv */
// Front end: position tracking, line stores, window register and border masking.
`default_nettype none
module mf3_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mf3_pkg::WIDTH_W-1:0]   frame_width,
  input  wire logic [mf3_pkg::HEIGHT_W-1:0]  frame_height,
  input  wire logic                          color_mode,
  mf3_pix_if.sink                            pix_in,
  input  wire logic                          room,
  output logic                               win_valid,
  output mf3_pkg::win_t                      win
);
  localparam int CW = mf3_pkg::WIDTH_W;
  localparam int HW = mf3_pkg::HEIGHT_W;
  localparam int RW = mf3_pkg::ROW_W;

  mf3_pkg::pix_t mem_upper [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t mem_lower [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t rd_upper, rd_lower;
  mf3_pkg::pix_t byp_upper, byp_lower;
  mf3_pkg::pix_t cells [mf3_pkg::TAPS];
  mf3_pkg::pix_t cells_next [mf3_pkg::TAPS];

  logic [mf3_pkg::COL_W-1:0] col, col_next;
  logic [RW-1:0]             row, row_next;
  logic                      clearing;
  logic [mf3_pkg::COL_W-1:0] clr_addr;

  logic                      s1_valid, s1_emit, s1_last, s1_byp;
  logic [mf3_pkg::COL_W-1:0] s1_addr;
  mf3_pkg::pix_t             s1_pix;
  logic [2:0]                s1_rok, s1_cok;

  logic [CW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;
  logic [CW-1:0]             c_cur;
  logic [RW:0]               r_cur;
  logic [CW:0]               c_inc;
  logic                      accept, emit, last;
  mf3_pkg::pix_t             pix;
  logic signed [RW+1:0]      cr, nr, h_s;
  logic signed [CW+1:0]      cc, nc, w_s;
  logic [2:0]                rok, cok;
  mf3_pkg::pix_t             col0, col1;

  assign pix_in.ready = !clearing && room;
  assign accept = pix_in.valid && pix_in.ready;

  // Effective frame size and the normalized position of this item.
  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) w_eff = CW'(1);
    if (frame_width > CW'(mf3_pkg::MAX_WIDTH)) w_eff = CW'(mf3_pkg::MAX_WIDTH);
    h_eff = (frame_height == '0) ? HW'(1) : frame_height;

    if (CW'(col) >= w_eff) begin
      c_cur = '0;
      r_cur = (RW+1)'(row) + 1'b1;
    end else begin
      c_cur = CW'(col);
      r_cur = (RW+1)'(row);
    end
    if (r_cur > (RW+1)'(h_eff) + 1'b1) begin
      c_cur = '0;
      r_cur = '0;
    end

    pix = '0;
    if (!pix_in.is_flush && (r_cur < (RW+1)'(h_eff))) begin
      pix[0] = pix_in.chan_a;
      pix[1] = pix_in.chan_b;
      pix[2] = pix_in.chan_c;
    end

    // Center of the window that this item completes.
    h_s = $signed((RW+2)'(h_eff));
    w_s = $signed((CW+2)'(w_eff));
    if (c_cur != '0) begin
      cr = $signed((RW+2)'(r_cur)) - 1;
      cc = $signed((CW+2)'(c_cur)) - 1;
    end else begin
      cr = $signed((RW+2)'(r_cur)) - 2;
      cc = w_s - 1;
    end
    emit = (cr >= 0) && (cr < h_s);
    last = emit && (cr == h_s - 1) && (cc == w_s - 1);

    for (int i = 0; i < 3; i++) begin
      nr = cr - 1 + (RW+2)'(i);
      nc = cc - 1 + (CW+2)'(i);
      rok[i] = (nr >= 0) && (nr < h_s);
      cok[i] = (nc >= 0) && (nc < w_s);
    end

    // Position of the following item.
    c_inc = (CW+1)'(c_cur) + 1'b1;
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (c_inc >= (CW+1)'(w_eff)) begin
      col_next = '0;
      row_next = RW'(r_cur + 1'b1);
    end else begin
      col_next = c_inc[mf3_pkg::COL_W-1:0];
      row_next = RW'(r_cur);
    end
  end

  // Position counters and the clearing pass over the line stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == mf3_pkg::COL_W'(mf3_pkg::MAX_WIDTH - 1)) clearing <= 1'b0;
      end
    end
  end

  // Item fields carried into the window stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= c_cur[mf3_pkg::COL_W-1:0];
      s1_pix  <= pix;
      s1_emit <= emit;
      s1_last <= last;
      s1_rok  <= rok;
      s1_cok  <= cok;
      s1_byp  <= s1_valid && (s1_addr == c_cur[mf3_pkg::COL_W-1:0]);
    end
    if (s1_valid) begin
      byp_upper <= col1;
      byp_lower <= s1_pix;
    end
  end

  // Line stores: read at acceptance, written back in the following cycle.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem_upper[clr_addr] <= '0;
      mem_lower[clr_addr] <= '0;
    end else if (s1_valid) begin
      mem_upper[s1_addr] <= col1;
      mem_lower[s1_addr] <= s1_pix;
    end
    if (accept) begin
      rd_upper <= mem_upper[c_cur[mf3_pkg::COL_W-1:0]];
      rd_lower <= mem_lower[c_cur[mf3_pkg::COL_W-1:0]];
    end
  end

  // New column enters the window; the previous item's write is forwarded.
  always_comb begin
    col0 = s1_byp ? byp_upper : rd_upper;
    col1 = s1_byp ? byp_lower : rd_lower;
    for (int i = 0; i < 3; i++) begin
      cells_next[i*3]   = cells[i*3+1];
      cells_next[i*3+1] = cells[i*3+2];
    end
    cells_next[2] = col0;
    cells_next[5] = col1;
    cells_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mf3_pkg::TAPS; k++) cells[k] <= '0;
    end else if (s1_valid) begin
      for (int k = 0; k < mf3_pkg::TAPS; k++) cells[k] <= cells_next[k];
    end
  end

  // Taps outside the frame read as zero; grey mode zeroes the second and third channels.
  always_comb begin
    win.frame_end = s1_last;
    for (int k = 0; k < mf3_pkg::TAPS; k++) begin
      win.taps[k] = (s1_rok[k/3] && s1_cok[k%3]) ? cells_next[k] : '0;
      if (!color_mode) begin
        win.taps[k][1] = '0;
        win.taps[k][2] = '0;
      end
    end
  end

  assign win_valid = s1_valid && s1_emit;
endmodule
`default_nettype wire

/* rtl/mf3_queue.sv */
// Short queue of windows between the front end and the median network.
`default_nettype none
module mf3_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  mf3_pkg::win_t       push_data,
  output logic                room,
  output logic                valid,
  output mf3_pkg::win_t       data,
  input  wire logic           pop,
  output mf3_pkg::q_stat_t    stat
);
  mf3_pkg::win_t                entries [mf3_pkg::QUEUE_DEPTH];
  logic [mf3_pkg::QPTR_W-1:0]   rd_ptr, wr_ptr;
  logic [mf3_pkg::QCNT_W-1:0]   count;

  // Room for the item in the window stage plus one more accepted now.
  assign room  = count <= mf3_pkg::QCNT_W'(mf3_pkg::QUEUE_DEPTH - 2);
  assign valid = count != '0;
  assign data  = entries[rd_ptr];

  always_comb begin
    stat.count = count;
    stat.push  = push;
    stat.pop   = pop;
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + mf3_pkg::QCNT_W'(push) - mf3_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end
endmodule
`default_nettype wire

/* rtl/mf3_back.sv */
// Back end: three-stage median network whose last stage is the output register.
`default_nettype none
module mf3_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  mf3_pkg::win_t  q_data,
  output logic           q_pop,
  mf3_med_if.source      med_out
);
  localparam int NC = mf3_pkg::CHANNELS;

  function automatic mf3_pkg::chan_t min2(mf3_pkg::chan_t x, mf3_pkg::chan_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic mf3_pkg::chan_t max2(mf3_pkg::chan_t x, mf3_pkg::chan_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic mf3_pkg::chan_t med3(mf3_pkg::chan_t x, mf3_pkg::chan_t y,
                                          mf3_pkg::chan_t z);
    return max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  logic           en;
  logic           a_valid, b_valid, o_valid;
  logic           a_end, b_end, o_end;
  mf3_pkg::chan_t a_lo [NC][3];
  mf3_pkg::chan_t a_mi [NC][3];
  mf3_pkg::chan_t a_hi [NC][3];
  mf3_pkg::chan_t b_mx [NC];
  mf3_pkg::chan_t b_md [NC];
  mf3_pkg::chan_t b_mn [NC];
  mf3_pkg::chan_t o_med [NC];

  // The whole network advances together when the output register can move.
  assign en    = !o_valid || med_out.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      a_valid <= q_valid;
      b_valid <= a_valid;
      o_valid <= b_valid;
    end
  end

  // Stage A sorts each window column; B takes max of lows, median of middles,
  // min of highs; the output stage takes the median of those three.
  always_ff @(posedge clk) begin
    if (en) begin
      a_end <= q_data.frame_end;
      b_end <= a_end;
      o_end <= b_end;
      for (int k = 0; k < NC; k++) begin
        for (int j = 0; j < 3; j++) begin
          a_lo[k][j] <= min2(min2(q_data.taps[j][k], q_data.taps[j+3][k]),
                             q_data.taps[j+6][k]);
          a_mi[k][j] <= med3(q_data.taps[j][k], q_data.taps[j+3][k],
                             q_data.taps[j+6][k]);
          a_hi[k][j] <= max2(max2(q_data.taps[j][k], q_data.taps[j+3][k]),
                             q_data.taps[j+6][k]);
        end
        b_mx[k]  <= max2(max2(a_lo[k][0], a_lo[k][1]), a_lo[k][2]);
        b_md[k]  <= med3(a_mi[k][0], a_mi[k][1], a_mi[k][2]);
        b_mn[k]  <= min2(min2(a_hi[k][0], a_hi[k][1]), a_hi[k][2]);
        o_med[k] <= med3(b_mx[k], b_md[k], b_mn[k]);
      end
    end
  end

  assign med_out.valid     = o_valid;
  assign med_out.med_a     = o_med[0];
  assign med_out.med_b     = o_med[1];
  assign med_out.med_c     = o_med[2];
  assign med_out.frame_end = o_end;
endmodule
`default_nettype wire

/* rtl/median_filter_3x3_unit.sv */
// The item that completes a window passes through the window stage, the queue, network
// stages A and B and the output register; that item comes one line plus one pixel after
// the center pixel. Throughput: one item per cycle while the queue has room, set by one
// read and one write-back of each line store. After reset the input is held not ready
// while both line stores are cleared one entry per cycle; configuration writes are
// taken throughout. Registers reset to width 640, height 480, grey mode.
`default_nettype none
`include "median_filter_3x3_unit_macros.svh"
module median_filter_3x3_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data,
  mf3_pix_if.sink                               pix_in,
  mf3_med_if.source                             med_out
);
  logic [mf3_pkg::WIDTH_W-1:0]  frame_width;
  logic [mf3_pkg::HEIGHT_W-1:0] frame_height;
  logic                         color_mode;
  logic                         room, win_valid, q_valid, q_pop;
  mf3_pkg::win_t                win, q_data;
  mf3_pkg::q_stat_t             q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mf3_pkg::WIDTH_W'(640);
      frame_height <= mf3_pkg::HEIGHT_W'(480);
      color_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mf3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[mf3_pkg::WIDTH_W-1:0];
        mf3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[mf3_pkg::HEIGHT_W-1:0];
        mf3_pkg::CFG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mf3_front u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .color_mode   (color_mode),
    .pix_in       (pix_in),
    .room         (room),
    .win_valid    (win_valid),
    .win          (win)
  );

  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (win_valid),
    .push_data (win),
    .room      (room),
    .valid     (q_valid),
    .data      (q_data),
    .pop       (q_pop),
    .stat      (q_stat)
  );

  mf3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .med_out (med_out)
  );

  // The line store clearing pass holds off input right after reset.
  `MF3_CHECK_NEXT(a_clear_after_reset, rst, !pix_in.ready)
  // Input flow control keeps the queue from overflowing.
  `MF3_CHECK(a_queue_no_overflow, q_stat.push,
             q_stat.count < mf3_pkg::QCNT_W'(mf3_pkg::QUEUE_DEPTH))
  // The median network only pops windows that are present.
  `MF3_CHECK(a_queue_no_underflow, q_stat.pop, q_stat.count != '0)
endmodule
`default_nettype wire
